### rtl/spq_pkg.sv
`timescale 1ns / 1ps

package spq_pkg;

  // Default sizing
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int TAG_BITS_DEF    = 16;

  // Fixed field widths on the ports
  localparam int TAG_W    = 16;
  localparam int STATUS_W = 2;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_ACCEPTED = 2'd0,
    ST_DROPPED  = 2'd1,
    ST_SERVED   = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  // Transaction kinds
  localparam logic KIND_ARRIVAL = 1'b0;
  localparam logic KIND_SERVE   = 1'b1;

  // Priority classes
  localparam logic CLASS_HIGH = 1'b0;
  localparam logic CLASS_LOW  = 1'b1;

  // Per-cycle command from a queue to each of its cells
  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctl_t;

  // Queue status toward the scheduler
  typedef struct packed {
    logic nonempty;
    logic full;
  } queue_stat_t;

endpackage

### rtl/two_class_strict_priority_queue_core.sv
`timescale 1ns / 1ps

// Channel  Dir  Ports          Contents
// in       in   in_t*          tuser[0] kind; tdata[0] client_class, tdata[16:1] tag
// out      out  out_t*         tuser[1:0] status; tdata[15:0] served_tag, tdata[16] class
//
// The two queues are rows of cells that shift toward the head on a serve
// and fill the first free cell on an arrival, so one item is taken per
// cycle while the input is not stalled, and its status is registered.
// Reset (rst_n low, synchronous) empties both queues and the output stage.
// The input stalls only while a result is held and out_tready is low.

module two_class_strict_priority_queue_core
  import spq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int TAG_BITS    = TAG_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [0] client_class, [16:1] tag, [23:17] zero
  input  logic [0:0]  in_tuser,   // [0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [15:0] served_tag, [16] served_class, [23:17] zero
  output logic [1:0]  out_tuser   // [1:0] status
);

  logic                in_acc;
  logic                in_kind;
  logic                in_class;
  logic [TAG_W-1:0]    in_tag;
  logic [TAG_BITS-1:0] push_tag;

  cell_ctl_t           hi_ctl, lo_ctl;
  queue_stat_t         hi_stat, lo_stat;
  logic [TAG_BITS-1:0] hi_head, lo_head;

  status_t             res_status;
  logic [TAG_W-1:0]    res_tag;
  logic                res_class;

  logic                out_valid_r, out_valid_nxt;
  status_t             status_r;
  logic [TAG_W-1:0]    tag_r;
  logic                class_r;

  // Unpack the input transaction
  assign in_kind  = in_tuser[0];
  assign in_class = in_tdata[0];
  assign in_tag   = in_tdata[16:1];
  assign push_tag = TAG_BITS'(in_tag);

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  // Route arrivals by class, serve high before low
  always_comb begin
    hi_ctl     = '0;
    lo_ctl     = '0;
    res_status = ST_EMPTY;
    res_tag    = '0;
    res_class  = CLASS_HIGH;
    if (in_kind == KIND_ARRIVAL) begin
      if (in_class == CLASS_HIGH) begin
        hi_ctl.push = in_acc && !hi_stat.full;
        res_status  = hi_stat.full ? ST_DROPPED : ST_ACCEPTED;
      end else begin
        lo_ctl.push = in_acc && !lo_stat.full;
        res_status  = lo_stat.full ? ST_DROPPED : ST_ACCEPTED;
      end
    end else begin
      priority if (hi_stat.nonempty) begin
        hi_ctl.pop = in_acc;
        res_status = ST_SERVED;
        res_tag    = TAG_W'(hi_head);
        res_class  = CLASS_HIGH;
      end else if (lo_stat.nonempty) begin
        lo_ctl.pop = in_acc;
        res_status = ST_SERVED;
        res_tag    = TAG_W'(lo_head);
        res_class  = CLASS_LOW;
      end else begin
        res_status = ST_EMPTY;
      end
    end
  end

  spq_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .TAG_BITS   (TAG_BITS)
  ) u_high (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (hi_ctl),
    .push_tag (push_tag),
    .stat     (hi_stat),
    .head_tag (hi_head)
  );

  spq_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .TAG_BITS   (TAG_BITS)
  ) u_low (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (lo_ctl),
    .push_tag (push_tag),
    .stat     (lo_stat),
    .head_tag (lo_head)
  );

  // Hold the result until taken, load a new one on accept
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_acc) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      status_r <= res_status;
      tag_r    <= res_tag;
      class_r  <= res_class;
    end
  end

  // Pack the result transaction
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, class_r, tag_r};
  assign out_tuser  = status_r;

endmodule

### rtl/spq_cell.sv
`timescale 1ns / 1ps

module spq_cell
  import spq_pkg::*;
#(
  parameter int TAG_BITS = TAG_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cell_ctl_t           ctl,
  input  logic                prev_valid,
  input  logic                next_valid,
  input  logic [TAG_BITS-1:0] next_tag,
  input  logic [TAG_BITS-1:0] push_tag,
  output logic                valid,
  output logic [TAG_BITS-1:0] tag
);

  logic                valid_r, valid_nxt;
  logic [TAG_BITS-1:0] tag_r, tag_nxt;

  // Shift toward the head on pop; capture at the first free cell on push
  always_comb begin
    valid_nxt = valid_r;
    tag_nxt   = tag_r;
    if (ctl.pop) begin
      valid_nxt = next_valid;
      tag_nxt   = next_tag;
    end else if (ctl.push && !valid_r && prev_valid) begin
      valid_nxt = 1'b1;
      tag_nxt   = push_tag;
    end
  end

  // Occupancy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Tag payload
  always_ff @(posedge clk) begin
    tag_r <= tag_nxt;
  end

  assign valid = valid_r;
  assign tag   = tag_r;

endmodule

### rtl/spq_queue.sv
`timescale 1ns / 1ps

module spq_queue
  import spq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int TAG_BITS    = TAG_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cell_ctl_t           ctl,
  input  logic [TAG_BITS-1:0] push_tag,
  output queue_stat_t         stat,
  output logic [TAG_BITS-1:0] head_tag
);

  logic [QUEUE_DEPTH-1:0] valid;
  logic [TAG_BITS-1:0]    tags [QUEUE_DEPTH];

  // Row of cells, cell 0 holds the oldest entry
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                pv;
    logic                nv;
    logic [TAG_BITS-1:0] nt;

    if (i == 0) begin : g_first
      assign pv = 1'b1;
    end else begin : g_mid
      assign pv = valid[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign nv = 1'b0;
      assign nt = '0;
    end else begin : g_inner
      assign nv = valid[i+1];
      assign nt = tags[i+1];
    end

    spq_cell #(
      .TAG_BITS(TAG_BITS)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .prev_valid (pv),
      .next_valid (nv),
      .next_tag   (nt),
      .push_tag   (push_tag),
      .valid      (valid[i]),
      .tag        (tags[i])
    );
  end

  assign stat.nonempty = valid[0];
  assign stat.full     = valid[QUEUE_DEPTH-1];
  assign head_tag      = tags[0];

endmodule
